FILE: design/stsched_pkg.sv
package stsched_pkg;

  typedef enum logic [1:0] {
    FN_SET   = 2'd0,
    FN_KILL  = 2'd1,
    FN_QUERY = 2'd2,
    FN_TICK  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KD_FIRE  = 2'd0,
    KD_ACK   = 2'd1,
    KD_QUERY = 2'd2,
    KD_DONE  = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_KILL  = 5'b00010,
    ST_QUERY = 5'b00100,
    ST_FIRE  = 5'b01000,
    ST_REARM = 5'b10000
  } state_t;

  localparam int TIME_W   = 32;
  localparam int DELAY_W  = 31;
  localparam int LIMIT_W  = 17;
  localparam int OTAG_W   = 16;

endpackage

FILE: design/software_timer_scheduler_core.sv
// Set, and a tick whose time equals the previous tick, answer from the idle state without a scan.
// Kill and query read every slot once.
// A tick makes one pass over the slot memory per fired timer and per re-armed
// timer, plus one empty pass of each kind.
// Results are strobed for one cycle each; the receiver cannot stall them.
// Synchronous reset empties the table; no clearing pass is needed.
module software_timer_scheduler_core #(
  parameter int SLOTS    = 32,
  parameter int TAG_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_func,
  input  logic [stsched_pkg::TIME_W-1:0]    in_now,
  input  logic signed [stsched_pkg::DELAY_W-1:0] in_delay,
  input  logic [TAG_BITS-1:0]               in_tag,
  input  logic [stsched_pkg::LIMIT_W-1:0]   in_tag_limit,
  output logic                              out_valid,
  output logic [1:0]                        out_kind,
  output logic [stsched_pkg::OTAG_W-1:0]    out_fired_tag,
  output logic                              out_found,
  output logic                              out_overflow,
  output logic                              out_last
);
  import stsched_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int CMPW = TAG_BITS + LIMIT_W;
  localparam int WORD_W = TAG_BITS + TIME_W + DELAY_W + TIME_W;
  localparam int DUE_LO = 0;
  localparam int PER_LO = TIME_W;
  localparam int ORD_LO = TIME_W + DELAY_W;
  localparam int TAG_LO = TIME_W + DELAY_W + TIME_W;

  function automatic logic [TIME_W-1:0] magnitude(input logic [DELAY_W-1:0] d);
    logic [DELAY_W-1:0] m;
    begin
      m = d[DELAY_W-1] ? (~d + 1'b1) : d;
      magnitude = {1'b0, m};
    end
  endfunction

  logic [WORD_W-1:0] mem [SLOTS];
  logic [WORD_W-1:0] rd_q_r;
  logic              we;
  logic [IW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;

  state_t state_r;
  logic [SLOTS-1:0] valid_r, fired_r;
  logic [TIME_W-1:0] next_order_r, last_tick_r;
  logic [TIME_W-1:0] now_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [CW-1:0] cnt_r;
  logic rd_v_r;
  logic [IW-1:0] rd_idx_r;
  logic have_r, found_r;
  logic [TIME_W-1:0] best_r, best_age_r;
  logic [IW-1:0] pick_r;
  logic [TAG_BITS-1:0] pick_tag_r;
  logic [DELAY_W-1:0] pick_per_r;

  logic out_valid_r, out_found_r, out_overflow_r, out_last_r;
  logic [1:0] out_kind_r;
  logic [OTAG_W-1:0] out_tag_r;

  logic [TIME_W-1:0] q_due, q_ord, tm, age;
  logic [DELAY_W-1:0] q_per;
  logic [TAG_BITS-1:0] q_tag;
  logic [CMPW-1:0] q_tag_x, lo_x, hi_x;
  logic [TAG_BITS+OTAG_W-1:0] pick_tag_x;
  logic free_any;
  logic [IW-1:0] free_idx;
  logic scan_end;

  assign q_due = rd_q_r[DUE_LO +: TIME_W];
  assign q_per = rd_q_r[PER_LO +: DELAY_W];
  assign q_ord = rd_q_r[ORD_LO +: TIME_W];
  assign q_tag = rd_q_r[TAG_LO +: TAG_BITS];
  assign tm = now_r - q_due;
  assign age = next_order_r - q_ord;
  assign q_tag_x = {{LIMIT_W{1'b0}}, q_tag};
  assign lo_x = {{LIMIT_W{1'b0}}, tag_r};
  assign hi_x = {{TAG_BITS{1'b0}}, limit_r};
  assign pick_tag_x = {{OTAG_W{1'b0}}, pick_tag_r};
  assign scan_end = (cnt_r == CW'(SLOTS)) && !rd_v_r;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = free_idx;
    wdata = {in_tag, next_order_r, in_delay, in_now + magnitude(in_delay)};
    if (state_r == ST_IDLE) begin
      we = start && (in_func == FN_SET) && free_any;
    end else if (state_r == ST_REARM) begin
      we = scan_end && have_r;
      waddr = pick_r;
      wdata = {pick_tag_r, next_order_r, pick_per_r, now_r + magnitude(pick_per_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q_r <= mem[cnt_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      fired_r <= '0;
      next_order_r <= '0;
      last_tick_r <= '0;
      out_valid_r <= 1'b0;
      cnt_r <= '0;
      rd_v_r <= 1'b0;
      have_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      out_kind_r <= KD_ACK;
      out_tag_r <= '0;
      out_found_r <= 1'b0;
      out_overflow_r <= 1'b0;
      out_last_r <= 1'b1;
      if (state_r != ST_IDLE) begin
        if (cnt_r < CW'(SLOTS)) begin
          cnt_r <= cnt_r + 1'b1;
          rd_v_r <= 1'b1;
          rd_idx_r <= cnt_r[IW-1:0];
        end else begin
          rd_v_r <= 1'b0;
        end
      end
      unique case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          rd_v_r <= 1'b0;
          have_r <= 1'b0;
          found_r <= 1'b0;
          now_r <= in_now;
          tag_r <= in_tag;
          limit_r <= in_tag_limit;
          if (start) begin
            unique case (in_func)
              FN_SET: begin
                out_valid_r <= 1'b1;
                if (free_any) begin
                  valid_r[free_idx] <= 1'b1;
                  fired_r[free_idx] <= 1'b0;
                  next_order_r <= next_order_r + 1'b1;
                end else begin
                  out_overflow_r <= 1'b1;
                end
              end
              FN_KILL: state_r <= ST_KILL;
              FN_QUERY: state_r <= ST_QUERY;
              default: begin
                if (in_now == last_tick_r) begin
                  out_valid_r <= 1'b1;
                  out_kind_r <= KD_DONE;
                end else begin
                  last_tick_r <= in_now;
                  state_r <= ST_FIRE;
                end
              end
            endcase
          end
        end
        ST_KILL: begin
          if (rd_v_r && valid_r[rd_idx_r] && q_tag_x >= lo_x && q_tag_x < hi_x) begin
            valid_r[rd_idx_r] <= 1'b0;
            fired_r[rd_idx_r] <= 1'b0;
          end
          if (scan_end) begin
            out_valid_r <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        ST_QUERY: begin
          if (rd_v_r && valid_r[rd_idx_r] && q_tag == tag_r) begin
            found_r <= 1'b1;
          end
          if (scan_end) begin
            out_valid_r <= 1'b1;
            out_kind_r <= KD_QUERY;
            out_found_r <= found_r;
            state_r <= ST_IDLE;
          end
        end
        ST_FIRE: begin
          if (rd_v_r && valid_r[rd_idx_r] && !fired_r[rd_idx_r] && !tm[TIME_W-1]) begin
            if (!have_r || tm > best_r || (tm == best_r && age > best_age_r)) begin
              have_r <= 1'b1;
              best_r <= tm;
              best_age_r <= age;
              pick_r <= rd_idx_r;
              pick_tag_r <= q_tag;
              pick_per_r <= q_per;
            end
          end
          if (scan_end) begin
            cnt_r <= '0;
            have_r <= 1'b0;
            if (have_r) begin
              out_valid_r <= 1'b1;
              out_kind_r <= KD_FIRE;
              out_tag_r <= pick_tag_x[OTAG_W-1:0];
              out_last_r <= 1'b0;
              if (pick_per_r[DELAY_W-1]) begin
                fired_r[pick_r] <= 1'b1;
              end else begin
                valid_r[pick_r] <= 1'b0;
              end
            end else begin
              state_r <= ST_REARM;
            end
          end
        end
        ST_REARM: begin
          if (rd_v_r && valid_r[rd_idx_r] && fired_r[rd_idx_r]) begin
            if (!have_r || age > best_age_r) begin
              have_r <= 1'b1;
              best_age_r <= age;
              pick_r <= rd_idx_r;
              pick_tag_r <= q_tag;
              pick_per_r <= q_per;
            end
          end
          if (scan_end) begin
            cnt_r <= '0;
            have_r <= 1'b0;
            if (have_r) begin
              fired_r[pick_r] <= 1'b0;
              next_order_r <= next_order_r + 1'b1;
            end else begin
              out_valid_r <= 1'b1;
              out_kind_r <= KD_DONE;
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_fired_tag = out_tag_r;
  assign out_found = out_found_r;
  assign out_overflow = out_overflow_r;
  assign out_last = out_last_r;

endmodule
